[rtl/core/hs_pkg.sv]
`timescale 1ns / 1ps

package hs_pkg;

	// Number of list entries the sorter can hold.
	localparam int unsigned CAPACITY = 64;

	// Width of one stored element.
	localparam int unsigned DATA_W = 32;

	// Address width of the element store.
	localparam int unsigned ADDR_W = $clog2(CAPACITY);

	// Width of the element count, which must also hold CAPACITY itself.
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	// Width of a child index, wide enough for the left child of any node.
	localparam int unsigned CHILD_W = ADDR_W + 1;

	typedef logic signed [DATA_W-1:0] elem_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [CHILD_W-1:0]       child_t;

endpackage

[rtl/core/hs_ram.sv]
`timescale 1ns / 1ps

module hs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/heap_sorter_top.sv]
`timescale 1ns / 1ps
// Loading accepts one value per cycle while busy is low; values beyond 64 are dropped.
// Sorting builds a max-heap by sifting each build root down, then swaps the largest value to the
// end n-1 times and sifts the new root down, level by level until it stays or a leaf is reached.
// The n results then follow on consecutive cycles, each in the cycle after emission issues the
// store read for it. The receiver cannot stall.
// arst_n clears the control state and the element count; the store contents are not cleared.

module heap_sorter_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hs_pkg::elem_t     value,
	input  logic              last,
	output logic              strobe,
	output hs_pkg::elem_t     sorted_value,
	output logic              last_out
);

	import hs_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_B_RD = 4'd1;
	localparam logic [3:0] ST_B_X  = 4'd2;
	localparam logic [3:0] ST_S_L  = 4'd3;
	localparam logic [3:0] ST_S_R  = 4'd4;
	localparam logic [3:0] ST_S_D  = 4'd5;
	localparam logic [3:0] ST_NEXT = 4'd6;
	localparam logic [3:0] ST_X_R0 = 4'd7;
	localparam logic [3:0] ST_X_RK = 4'd8;
	localparam logic [3:0] ST_X_W  = 4'd9;
	localparam logic [3:0] ST_EMIT = 4'd10;

	logic [3:0] state_q;
	cnt_t       count_q;
	cnt_t       n_q;
	cnt_t       size_q;
	addr_t      root_q;
	addr_t      k_q;
	addr_t      pos_q;
	addr_t      e_q;
	logic       build_q;
	elem_t      x_q;
	elem_t      lv_q;
	elem_t      rt_q;
	logic       strobe_q;
	logic       last_q;

	logic       ram_we;
	addr_t      ram_waddr;
	elem_t      ram_wdata;
	logic       ram_re;
	addr_t      ram_raddr;
	elem_t      ram_rdata;

	logic       accept;
	logic       keep;
	cnt_t       n_next;
	child_t     left_idx;
	child_t     right_idx;
	logic       left_ok;
	logic       right_ok;
	elem_t      top_val;
	child_t     top_idx;
	logic       top_is_pos;

	// Element store.
	hs_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start && !busy;
	assign keep         = (count_q < cnt_t'(CAPACITY));
	assign n_next       = keep ? count_q + cnt_t'(1) : count_q;
	assign strobe       = strobe_q;
	assign last_out     = last_q;
	assign sorted_value = ram_rdata;

	// Children of the current sift position and their presence in the heap.
	assign left_idx  = {pos_q, 1'b1};
	assign right_idx = child_t'({pos_q, 1'b1} + child_t'(1));
	assign left_ok   = (left_idx < child_t'(size_q));
	assign right_ok  = (right_idx < child_t'(size_q));

	// Pick the largest of the sifted value and its children; ties stay with the earlier one.
	always_comb begin
		top_val = x_q;
		top_idx = child_t'(pos_q);
		if (lv_q > x_q) begin
			top_val = lv_q;
			top_idx = left_idx;
		end
		if (right_ok && (ram_rdata > top_val)) begin
			top_val = ram_rdata;
			top_idx = right_idx;
		end
	end
	assign top_is_pos = (top_idx == child_t'(pos_q));

	// Store access for each state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = x_q;
		ram_re    = 1'b0;
		ram_raddr = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_we    = accept && keep;
				ram_waddr = count_q[ADDR_W-1:0];
				ram_wdata = value;
			end
			ST_B_RD: begin
				ram_re    = 1'b1;
				ram_raddr = root_q;
			end
			ST_S_L: begin
				if (left_ok) begin
					ram_re    = 1'b1;
					ram_raddr = left_idx[ADDR_W-1:0];
				end else begin
					ram_we = 1'b1;
				end
			end
			ST_S_R: begin
				ram_re    = right_ok;
				ram_raddr = right_idx[ADDR_W-1:0];
			end
			ST_S_D: begin
				ram_we    = 1'b1;
				ram_wdata = top_is_pos ? x_q : top_val;
			end
			ST_X_R0: begin
				ram_re    = 1'b1;
				ram_raddr = '0;
			end
			ST_X_RK: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
			end
			ST_X_W: begin
				ram_we    = 1'b1;
				ram_waddr = k_q;
				ram_wdata = rt_q;
			end
			ST_EMIT: begin
				ram_re    = 1'b1;
				ram_raddr = e_q;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: load, heap build, extraction and emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			n_q      <= '0;
			size_q   <= '0;
			root_q   <= '0;
			k_q      <= '0;
			pos_q    <= '0;
			e_q      <= '0;
			build_q  <= 1'b0;
			x_q      <= '0;
			lv_q     <= '0;
			rt_q     <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last) begin
							count_q <= '0;
							n_q     <= n_next;
							e_q     <= '0;
							if (n_next < cnt_t'(2)) begin
								state_q <= ST_EMIT;
							end else begin
								build_q <= 1'b1;
								root_q  <= addr_t'((n_next >> 1) - cnt_t'(1));
								state_q <= ST_B_RD;
							end
						end else begin
							count_q <= n_next;
						end
					end
				end
				ST_B_RD: begin
					state_q <= ST_B_X;
				end
				ST_B_X: begin
					x_q     <= ram_rdata;
					pos_q   <= root_q;
					size_q  <= n_q;
					state_q <= ST_S_L;
				end
				ST_S_L: begin
					state_q <= left_ok ? ST_S_R : ST_NEXT;
				end
				ST_S_R: begin
					lv_q    <= ram_rdata;
					state_q <= ST_S_D;
				end
				ST_S_D: begin
					if (top_is_pos) begin
						state_q <= ST_NEXT;
					end else begin
						pos_q   <= top_idx[ADDR_W-1:0];
						state_q <= ST_S_L;
					end
				end
				ST_NEXT: begin
					if (build_q) begin
						if (root_q == '0) begin
							build_q <= 1'b0;
							k_q     <= addr_t'(n_q - cnt_t'(1));
							state_q <= ST_X_R0;
						end else begin
							root_q  <= root_q - addr_t'(1);
							state_q <= ST_B_RD;
						end
					end else begin
						if (k_q == addr_t'(1)) begin
							e_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							k_q     <= k_q - addr_t'(1);
							state_q <= ST_X_R0;
						end
					end
				end
				ST_X_R0: begin
					state_q <= ST_X_RK;
				end
				ST_X_RK: begin
					rt_q    <= ram_rdata;
					state_q <= ST_X_W;
				end
				ST_X_W: begin
					// The old end value becomes the sifted value at the root.
					x_q     <= ram_rdata;
					pos_q   <= '0;
					size_q  <= cnt_t'(k_q);
					state_q <= ST_S_L;
				end
				ST_EMIT: begin
					last_q <= (cnt_t'(e_q) == n_q - cnt_t'(1));
					if (cnt_t'(e_q) == n_q - cnt_t'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						e_q <= e_q + addr_t'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
